### sv/assert_macros.svh
// Assertion helpers for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is high.
`define GSS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Property checked on every rising edge, reset included.
`define GSS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("%m: check failed");

`endif

### sv/gss_pkg.sv
`default_nettype none

package gss_pkg;

   // Defaults for the top level parameters
   localparam int NUM_CHANNELS_DEF = 6;
   localparam int MAX_STEPS_DEF    = 64;
   localparam int TICK_WIDTH_DEF   = 24;

   // Field widths
   localparam int LEN_W      = 7;
   localparam int PROB_W     = 17;
   localparam int DRAW_W     = 16;
   localparam int CH_W       = 3;
   localparam int PULSE_W    = 16;
   localparam int MODE_W     = 3;
   localparam int MAXP_W     = 24;
   localparam int OUT_CH     = 6;
   localparam int STEP_OUT_W = 6;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // Result packing
   localparam int RSP_GATE_LO = 0;
   localparam int RSP_GATE_HI = 5;
   localparam int RSP_STEP_LO = 6;
   localparam int RSP_STEP_HI = 11;
   localparam int RSP_BAR     = 12;
   localparam int RSP_BEAT    = 13;
   localparam int RSP_BANK    = 14;

   // Register reset values
   localparam logic [MODE_W-1:0]  METRO_RST  = 3'd2;
   localparam logic [PULSE_W-1:0] PULSE_RST  = 16'd48;
   localparam logic [PULSE_W-1:0] IGNORE_RST = 16'd48;
   localparam logic [MAXP_W-1:0]  MAXP_RST   = 24'd96000;

   // First metronome mode that never marks
   localparam logic [MODE_W-1:0]  METRO_NEVER = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_METRONOME   = 3'd0,
      CSR_WRITE_FILLS = 3'd1,
      CSR_PULSE       = 3'd2,
      CSR_IGNORE      = 3'd3,
      CSR_MAX_PERIOD  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_WRITE = 2'd1,
      PEND_DEL   = 2'd2
   } pend_kind_type;

   // Per-tick pattern edits, applied by the selected lane only
   typedef struct packed {
      logic big_now;
      logic bank_flip;
      logic clear;
      logic del_now;
      logic fill_set;
      logic late_apply;
      logic late_write;
      logic clk_apply;
      logic clk_write;
      logic toggle;
   } gss_lane_ctl_type;

   // Low step bits that must be zero for a beat mark
   function automatic logic [2:0] beat_mask(input logic [MODE_W-1:0] mode);
      logic [2:0] m;
      case (mode)
         3'd0:    m = 3'b000;
         3'd1:    m = 3'b001;
         3'd2:    m = 3'b011;
         default: m = 3'b111;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

### sv/gss_lane.sv
`default_nettype none

// One channel: two pattern banks, the bank select, and the edits of one tick.
module gss_lane import gss_pkg::*; #(
   parameter int MAX_STEPS = MAX_STEPS_DEF,
   parameter int SW        = $clog2(MAX_STEPS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             sel,
   input  wire gss_lane_ctl_type ctl,
   input  wire logic [SW-1:0]    old_step,
   input  wire logic [SW-1:0]    new_step,
   input  wire logic [SW-1:0]    out_step,
   output logic                  gate,
   output logic                  bank,
   output logic                  wrote
);

   localparam logic [MAX_STEPS-1:0] ONE = MAX_STEPS'(1);

   logic [MAX_STEPS-1:0] pat_ff [2];
   logic [MAX_STEPS-1:0] pat_in [2];
   logic                 bank_ff;

   always_comb begin
      logic [MAX_STEPS-1:0] old_m;
      logic [MAX_STEPS-1:0] new_m;
      logic [MAX_STEPS-1:0] out_m;
      logic [MAX_STEPS-1:0] p0;
      logic [MAX_STEPS-1:0] p1;
      logic [MAX_STEPS-1:0] cur;
      logic                 w1;
      logic                 w2;
      logic                 w3;
      old_m = ONE << old_step;
      new_m = ONE << new_step;
      out_m = ONE << out_step;
      p0    = pat_ff[0];
      p1    = pat_ff[1];
      w2    = 1'b0;
      w3    = 1'b0;

      // big button lands in the bank in use before any flip
      w1 = sel && ctl.big_now && (((bank_ff ? p1 : p0) & old_m) == '0);
      if (w1) begin
         if (bank_ff) begin
            p1 = p1 | old_m;
         end else begin
            p0 = p0 | old_m;
         end
      end

      bank = bank_ff ^ (sel & ctl.bank_flip);
      cur  = bank ? p1 : p0;

      if (sel) begin
         if (ctl.clear) begin
            cur = '0;
         end
         if (ctl.del_now) begin
            cur = cur & ~old_m;
         end
         if (ctl.fill_set) begin
            cur = cur | old_m;
         end
         // pending edit timed out: old step
         if (ctl.late_apply) begin
            if (ctl.late_write) begin
               w2  = (cur & old_m) == '0;
               cur = cur | old_m;
            end else begin
               cur = cur & ~old_m;
            end
         end
         // pending edit snapped to the step just reached
         if (ctl.clk_apply) begin
            if (ctl.clk_write) begin
               w3  = (cur & new_m) == '0;
               cur = cur | new_m;
            end else begin
               cur = cur & ~new_m;
            end
         end
         if (ctl.toggle) begin
            cur = cur ^ new_m;
         end
      end

      pat_in[0] = bank ? p0 : cur;
      pat_in[1] = bank ? cur : p1;
      gate      = (cur & out_m) != '0;
      wrote     = w1 | w2 | w3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff[0] <= '0;
         pat_ff[1] <= '0;
         bank_ff   <= 1'b0;
      end else if (en) begin
         pat_ff[0] <= pat_in[0];
         pat_ff[1] <= pat_in[1];
         bank_ff   <= bank;
      end
   end

endmodule

`default_nettype wire

### sv/gate_step_sequencer_unit.sv
// A taken request passes the input register, then the result register; one request per
// cycle is sustained while rsp_tready stays high. The whole tick update is one pass of
// logic between the two registers. Neither request nor register writes are taken during
// reset.
// Synchronous active-high reset: patterns and bank selects cleared, step 0, pending none,
// registers to their defaults, last period = default cap, ignore count = 48 ticks.
`default_nettype none

module gate_step_sequencer_unit import gss_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int MAX_STEPS    = MAX_STEPS_DEF,
   parameter int TICK_WIDTH   = TICK_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // clock_edge, reset_edge, big_edge, bank_edge, clear_level, delete_level,
   // fill_level, step_count[7], toggle_prob[17], random_draw[16], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // chan_select[3]
   input  wire logic [CH_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // gate_bits[6], step_index[6], bar_start, beat_mark, chan_bank, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SW = $clog2(MAX_STEPS);
   localparam int TW = TICK_WIDTH;
   localparam int PW = TW + 7;
   localparam int MW = (TW > MAXP_W) ? TW : MAXP_W;
   localparam longint unsigned TICK_MAX_L = (64'd1 << TW) - 64'd1;
   localparam logic [TW-1:0] TICK_MAX  = TW'(TICK_MAX_L);
   localparam logic [TW-1:0] LAST_RST  =
      (64'(MAXP_RST) > TICK_MAX_L) ? TICK_MAX : TW'(MAXP_RST);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_STEPS);

   // configuration
   logic [MODE_W-1:0]  metro_ff;
   logic               fills_ff;
   logic [PULSE_W-1:0] pulse_ff;
   logic [PULSE_W-1:0] ignore_cfg_ff;
   logic [MAXP_W-1:0]  maxp_ff;

   // tick state
   logic [SW-1:0]      step_ff;
   logic [TW-1:0]      since_ff;
   logic [TW-1:0]      last_ff;
   pend_kind_type      pend_ff;
   logic [PULSE_W-1:0] out_left_ff;
   logic [PULSE_W-1:0] big_left_ff;
   logic [PULSE_W-1:0] ign_left_ff;

   // input register and result register
   logic                  req_valid_ff;
   logic [REQ_DATA_W-1:0] req_data_ff;
   logic [CH_W-1:0]       req_user_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic fire;

   assign fire       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!req_valid_ff || fire);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = !reset;

   // request fields
   logic              f_clk, f_rst, f_big, f_bnk, f_clr, f_del, f_fill;
   logic [LEN_W-1:0]  f_len;
   logic [PROB_W-1:0] f_prob;
   logic [DRAW_W-1:0] f_draw;

   assign f_clk  = req_data_ff[0];
   assign f_rst  = req_data_ff[1];
   assign f_big  = req_data_ff[2];
   assign f_bnk  = req_data_ff[3];
   assign f_clr  = req_data_ff[4];
   assign f_del  = req_data_ff[5];
   assign f_fill = req_data_ff[6];
   assign f_len  = req_data_ff[13:7];
   assign f_prob = req_data_ff[30:14];
   assign f_draw = req_data_ff[46:31];

   // timing window against the last period
   logic [PW-1:0] since_x100;
   logic [PW-1:0] last_x101;
   logic          in_window;
   logic          late;

   assign since_x100 = PW'(since_ff) * PW'(100);
   assign last_x101  = PW'(last_ff) * PW'(101);
   assign in_window  = ({since_ff, 1'b0} > {1'b0, last_ff}) && (since_x100 <= last_x101);
   assign late       = since_x100 > last_x101;

   // step advance
   logic [LEN_W-1:0] len_c;
   logic [LEN_W-1:0] step_plus;
   logic [SW-1:0]    new_step;
   logic [SW-1:0]    out_step;
   logic             clk_ok;

   assign clk_ok    = f_clk && (ign_left_ff == '0);
   assign len_c     = (f_len == '0) ? LEN_W'(1) : ((f_len > LEN_MAX) ? LEN_MAX : f_len);
   assign step_plus = LEN_W'(step_ff) + LEN_W'(1);
   assign new_step  = (step_plus >= len_c) ? '0 : SW'(step_plus);
   assign out_step  = f_rst ? '0 : (clk_ok ? new_step : step_ff);

   // pending edit sequencing
   pend_kind_type    pend_a, pend_b, pend_in;
   gss_lane_ctl_type ctl;

   always_comb begin
      pend_a = pend_ff;
      if (f_big && in_window) begin
         pend_a = PEND_WRITE;
      end
      if (f_del && in_window) begin
         pend_a = PEND_DEL;
      end
      ctl.big_now    = f_big && !in_window;
      ctl.bank_flip  = f_bnk;
      ctl.clear      = f_clr;
      ctl.del_now    = f_del && !in_window;
      ctl.fill_set   = f_fill && fills_ff;
      ctl.late_apply = late && (pend_a != PEND_NONE);
      ctl.late_write = pend_a == PEND_WRITE;
      pend_b         = ctl.late_apply ? PEND_NONE : pend_a;
      ctl.clk_apply  = clk_ok && (pend_b != PEND_NONE);
      ctl.clk_write  = pend_b == PEND_WRITE;
      pend_in        = ctl.clk_apply ? PEND_NONE : pend_b;
      ctl.toggle     = clk_ok && ({1'b0, f_draw} < f_prob);
   end

   // channel lanes
   logic [NUM_CHANNELS-1:0] sel, lane_gate, lane_bank, lane_wrote;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      if (i == NUM_CHANNELS - 1) begin : g_last
         assign sel[i] = 5'(req_user_ff) >= 5'(NUM_CHANNELS - 1);
      end else begin : g_mid
         assign sel[i] = 5'(req_user_ff) == 5'(i);
      end
      gss_lane #(
         .MAX_STEPS (MAX_STEPS),
         .SW        (SW)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .en       (fire),
         .sel      (sel[i]),
         .ctl      (ctl),
         .old_step (step_ff),
         .new_step (new_step),
         .out_step (out_step),
         .gate     (lane_gate[i]),
         .bank     (lane_bank[i]),
         .wrote    (lane_wrote[i])
      );
   end

   // pulse and tick counters
   logic [PULSE_W-1:0] out_a, big_a, ign_a;
   logic [PULSE_W-1:0] out_left_in, big_left_in, ign_left_in;
   logic               outp, bigp;
   logic [TW-1:0]      since_a, since_in, last_in;

   assign out_a       = (clk_ok || f_rst) ? pulse_ff : out_left_ff;
   assign big_a       = (|lane_wrote) ? pulse_ff : big_left_ff;
   assign ign_a       = f_rst ? ignore_cfg_ff : ign_left_ff;
   assign outp        = out_a != '0;
   assign bigp        = big_a != '0;
   assign out_left_in = out_a - PULSE_W'(outp);
   assign big_left_in = big_a - PULSE_W'(bigp);
   assign ign_left_in = ign_a - PULSE_W'(ign_a != '0);
   assign since_a     = clk_ok ? '0 : since_ff;
   assign since_in    = since_a + TW'(since_a != TICK_MAX);
   assign last_in     = !clk_ok ? last_ff :
                        ((MW'(since_ff) > MW'(maxp_ff)) ? TW'(maxp_ff) : since_ff);

   // result
   logic [OUT_CH-1:0]     gate_bits;
   logic [STEP_OUT_W-1:0] new_step6;
   logic                  bar, beat;

   for (genvar i = 0; i < OUT_CH; i++) begin : g_gate
      if (i < NUM_CHANNELS) begin : g_on
         assign gate_bits[i] = ((lane_gate[i] || (sel[i] && f_fill)) && outp) ||
                               (lane_gate[i] && bigp && sel[i]);
      end else begin : g_off
         assign gate_bits[i] = 1'b0;
      end
   end

   assign new_step6 = STEP_OUT_W'(new_step);
   assign bar       = f_rst || (clk_ok && (new_step == '0));
   assign beat      = !f_rst && clk_ok && (new_step != '0) && (metro_ff < METRO_NEVER) &&
                      ((new_step6[2:0] & beat_mask(metro_ff)) == 3'b000);

   always_comb begin
      rsp_data_in                          = '0;
      rsp_data_in[RSP_GATE_HI:RSP_GATE_LO] = gate_bits;
      rsp_data_in[RSP_STEP_HI:RSP_STEP_LO] = STEP_OUT_W'(out_step);
      rsp_data_in[RSP_BAR]                 = bar;
      rsp_data_in[RSP_BEAT]                = beat;
      rsp_data_in[RSP_BANK]                = |(sel & lane_bank);
   end

   // handshake registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_data_ff <= req_tdata;
         req_user_ff <= req_tuser;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         metro_ff      <= METRO_RST;
         fills_ff      <= 1'b0;
         pulse_ff      <= PULSE_RST;
         ignore_cfg_ff <= IGNORE_RST;
         maxp_ff       <= MAXP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_METRONOME:   metro_ff      <= csr_data[MODE_W-1:0];
            CSR_WRITE_FILLS: fills_ff      <= csr_data[0];
            CSR_PULSE:       pulse_ff      <= csr_data[PULSE_W-1:0];
            CSR_IGNORE:      ignore_cfg_ff <= csr_data[PULSE_W-1:0];
            CSR_MAX_PERIOD:  maxp_ff       <= csr_data[MAXP_W-1:0];
            default: ;
         endcase
      end
   end

   // tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         since_ff    <= '0;
         last_ff     <= LAST_RST;
         pend_ff     <= PEND_NONE;
         out_left_ff <= '0;
         big_left_ff <= '0;
         ign_left_ff <= IGNORE_RST;
      end else if (fire) begin
         step_ff     <= out_step;
         since_ff    <= since_in;
         last_ff     <= last_in;
         pend_ff     <= pend_in;
         out_left_ff <= out_left_in;
         big_left_ff <= big_left_in;
         ign_left_ff <= ign_left_in;
      end
   end

endmodule

`default_nettype wire

### sv/gss_checker.sv
`default_nettype none
`include "assert_macros.svh"

module gss_checker import gss_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   `GSS_ASSERT_ALWAYS(a_reset_drops_rsp, clock, reset |=> !rsp_tvalid)

   `GSS_ASSERT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // a bar start always lands on step zero
   `GSS_ASSERT(a_bar_at_zero, clock, reset, rsp_tvalid && rsp_tdata[RSP_BAR] |-> rsp_tdata[RSP_STEP_HI:RSP_STEP_LO] == '0)

   // a beat mark never coincides with a bar start and never sits on step zero
   `GSS_ASSERT(a_beat_off_bar, clock, reset, rsp_tvalid && rsp_tdata[RSP_BEAT] |-> !rsp_tdata[RSP_BAR] && rsp_tdata[RSP_STEP_HI:RSP_STEP_LO] != '0)

endmodule

bind gate_step_sequencer_unit gss_checker u_gss_checker (.*);

`default_nettype wire
